>>> rtl/bwcb_pkg.sv
package bwcb_pkg;

  localparam int IDX_IN_W = 8;
  localparam int W_W      = 17;
  localparam int OUT_W    = 17;
  localparam int SUM_W    = 34;
  localparam int BASE_W   = 3;

  localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(65536);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIG_MUL,
    ST_DIG_UPD,
    ST_DIV,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_EMIT
  } bwcb_state_e;

  typedef struct packed {
    logic       load_item;
    logic       load_digits;
    logic       div_init;
    logic       digit_mul;
    logic       digit_upd;
    logic       div_step;
    logic       mac_mul;
    logic       mac_acc;
    logic       emit;
    logic [1:0] chan;
  } bwcb_ctrl_t;

  typedef struct packed {
    logic x_zero;
    logic div_last;
    logic last_entry;
    logic out_free;
  } bwcb_stat_t;

  // Halton base of each color channel.
  function automatic logic [BASE_W-1:0] base_of(input logic [1:0] chan);
    logic [BASE_W-1:0] b;
    unique case (chan)
      CH_RED:   b = BASE_W'(2);
      CH_GREEN: b = BASE_W'(3);
      CH_BLUE:  b = BASE_W'(5);
      default:  b = BASE_W'(2);
    endcase
    return b;
  endfunction

endpackage

>>> rtl/bwcb_mul.sv
module bwcb_mul #(
  parameter int A_W = 16,
  parameter int B_W = 17
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/bwcb_ctrl.sv
module bwcb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_entry_i,
  input  logic                 bone_tint_i,
  input  bwcb_pkg::bwcb_stat_t stat_i,
  output logic                 in_ready_o,
  output bwcb_pkg::bwcb_ctrl_t ctrl_o
);

  bwcb_pkg::bwcb_state_e state_q, state_d;
  logic [1:0]            chan_q, chan_d;
  logic                  accept;

  assign accept = in_valid_i && (state_q == bwcb_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwcb_pkg::ST_IDLE;
      chan_q  <= bwcb_pkg::CH_RED;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    unique case (state_q)
      bwcb_pkg::ST_IDLE: begin
        if (accept) begin
          chan_d = bwcb_pkg::CH_RED;
          if (bone_tint_i) begin
            state_d = bwcb_pkg::ST_DIG_MUL;
          end else if (last_entry_i) begin
            state_d = bwcb_pkg::ST_EMIT;
          end
        end
      end
      bwcb_pkg::ST_DIG_MUL: begin
        state_d = stat_i.x_zero ? bwcb_pkg::ST_DIV : bwcb_pkg::ST_DIG_UPD;
      end
      bwcb_pkg::ST_DIG_UPD: begin
        state_d = bwcb_pkg::ST_DIG_MUL;
      end
      bwcb_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = bwcb_pkg::ST_MAC_MUL;
        end
      end
      bwcb_pkg::ST_MAC_MUL: begin
        state_d = bwcb_pkg::ST_MAC_ACC;
      end
      bwcb_pkg::ST_MAC_ACC: begin
        if (chan_q == bwcb_pkg::CH_BLUE) begin
          state_d = stat_i.last_entry ? bwcb_pkg::ST_EMIT : bwcb_pkg::ST_IDLE;
        end else begin
          chan_d  = 2'(chan_q + 2'd1);
          state_d = bwcb_pkg::ST_DIG_MUL;
        end
      end
      bwcb_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = bwcb_pkg::ST_IDLE;
        end
      end
      default: state_d = bwcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.chan = chan_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      bwcb_pkg::ST_IDLE: begin
        in_ready_o         = 1'b1;
        ctrl_o.load_item   = accept;
        ctrl_o.load_digits = accept && bone_tint_i;
      end
      bwcb_pkg::ST_DIG_MUL: begin
        ctrl_o.digit_mul = !stat_i.x_zero;
        ctrl_o.div_init  = stat_i.x_zero;
      end
      bwcb_pkg::ST_DIG_UPD: ctrl_o.digit_upd = 1'b1;
      bwcb_pkg::ST_DIV:     ctrl_o.div_step  = 1'b1;
      bwcb_pkg::ST_MAC_MUL: ctrl_o.mac_mul   = 1'b1;
      bwcb_pkg::ST_MAC_ACC: begin
        ctrl_o.mac_acc     = 1'b1;
        ctrl_o.load_digits = (chan_q != bwcb_pkg::CH_BLUE);
      end
      bwcb_pkg::ST_EMIT:    ctrl_o.emit      = stat_i.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_chan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.mac_acc && chan_q != bwcb_pkg::CH_BLUE) |=>
      (state_q == bwcb_pkg::ST_DIG_MUL && chan_q == 2'($past(chan_q) + 2'd1)))
    else $error("channel did not advance after accumulate");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bwcb_pkg::ST_EMIT && !stat_i.out_free) |=> state_q == bwcb_pkg::ST_EMIT)
    else $error("pending result dropped");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bwcb_pkg::ST_DIG_UPD) |-> $past(ctrl_o.digit_mul))
    else $error("digit update without a product");
`endif

endmodule

>>> rtl/bone_weight_color_blend.sv
// Sequence, white mode: a last entry goes to the emit state before the input is ready again;
// other entries are taken back to back. Color mode: per channel, the digit loop alternates
// multiply and update for each digit of the index in that channel's base, then a restoring
// divider makes FRAC_BITS fraction bits and a multiply and an accumulate add the weighted
// color; a last entry then passes through the emit state, which waits for a free output.
// Reset (asynchronous, active low) clears the channel sums, the mode bit and the sequencer.
module bone_weight_color_blend #(
  parameter int BONE_BITS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bwcb_pkg::IDX_IN_W-1:0]  bone_index_i,
  input  logic [bwcb_pkg::W_W-1:0]       weight_i,
  input  logic                           last_entry_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bwcb_pkg::OUT_W-1:0]     red_o,
  output logic [bwcb_pkg::OUT_W-1:0]     green_o,
  output logic [bwcb_pkg::OUT_W-1:0]     blue_o
);

  localparam int IDX_W = (BONE_BITS < bwcb_pkg::IDX_IN_W) ? BONE_BITS : bwcb_pkg::IDX_IN_W;
  localparam int SH    = IDX_W + 3;
  localparam int DEN_W = IDX_W + 3;
  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam int A_W   = (FRAC_BITS > IDX_W) ? FRAC_BITS : IDX_W;
  localparam int B_W   = (SH > bwcb_pkg::W_W) ? SH : bwcb_pkg::W_W;
  localparam int P_W   = A_W + B_W;
  localparam int SUM_W = bwcb_pkg::SUM_W;
  localparam int OUT_W = bwcb_pkg::OUT_W;

  localparam logic [SH-1:0] RECIP2 = SH'(((1 << SH) + 1) / 2);
  localparam logic [SH-1:0] RECIP3 = SH'(((1 << SH) + 2) / 3);
  localparam logic [SH-1:0] RECIP5 = SH'(((1 << SH) + 4) / 5);

  bwcb_pkg::bwcb_ctrl_t ctrl;
  bwcb_pkg::bwcb_stat_t stat;

  logic                       bone_tint_q;
  logic [IDX_W-1:0]           idx_q, x_q;
  logic [bwcb_pkg::W_W-1:0]   weight_q;
  logic                       last_q;
  logic [DEN_W-1:0]           num_q, den_q, rem_q;
  logic [FRAC_BITS-1:0]       col_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [SUM_W-1:0]           sum_q [3];
  logic                       out_valid_q;
  logic [OUT_W-1:0]           red_q, green_q, blue_q;

  logic [bwcb_pkg::BASE_W-1:0] base;
  logic [SH-1:0]               recip;
  logic                        mul_en;
  logic [A_W-1:0]              mul_a;
  logic [B_W-1:0]              mul_b;
  logic [P_W-1:0]              mul_p;
  logic [IDX_W-1:0]            quo;
  logic [DEN_W-1:0]            quo_b, dig;
  logic [DEN_W-1:0]            num_next, den_next;
  logic [DEN_W:0]              rem2, rem_sub;
  logic                        ge;
  logic [DEN_W-1:0]            rem_next;
  logic [bwcb_pkg::W_W-1:0]    add;
  logic [SUM_W:0]              sum_ext;
  logic [SUM_W-1:0]            sum_sat;

  function automatic logic [OUT_W-1:0] clamp_one(input logic [SUM_W-1:0] s);
    return (s > SUM_W'(bwcb_pkg::ONE_Q16)) ? bwcb_pkg::ONE_Q16 : s[OUT_W-1:0];
  endfunction

  bwcb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_entry_i  (last_entry_i),
    .bone_tint_i   (bone_tint_q),
    .stat_i        (stat),
    .in_ready_o    (in_ready_o),
    .ctrl_o        (ctrl)
  );

  assign stat.x_zero     = (x_q == '0);
  assign stat.div_last   = (cnt_q == CNT_W'(FRAC_BITS - 1));
  assign stat.last_entry = last_q;
  assign stat.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    base = bwcb_pkg::base_of(ctrl.chan);
    unique case (ctrl.chan)
      bwcb_pkg::CH_RED:   recip = RECIP2;
      bwcb_pkg::CH_GREEN: recip = RECIP3;
      bwcb_pkg::CH_BLUE:  recip = RECIP5;
      default:            recip = RECIP2;
    endcase
  end

  assign mul_en = ctrl.digit_mul || ctrl.mac_mul;
  assign mul_a  = ctrl.mac_mul ? A_W'(col_q) : A_W'(x_q);
  assign mul_b  = ctrl.mac_mul ? B_W'(weight_q) : B_W'(recip);

  bwcb_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // One digit: quotient from the reciprocal product, remainder by back-multiplication.
  assign quo      = mul_p[SH +: IDX_W];
  assign quo_b    = DEN_W'(quo) * DEN_W'(base);
  assign dig      = DEN_W'(x_q) - quo_b;
  assign num_next = DEN_W'(num_q * DEN_W'(base)) + dig;
  assign den_next = DEN_W'(den_q * DEN_W'(base));

  // One restoring division step for the fractional bits of num / den.
  assign rem2     = {rem_q, 1'b0};
  assign rem_sub  = rem2 - {1'b0, den_q};
  assign ge       = (rem2 >= {1'b0, den_q});
  assign rem_next = ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];

  assign add      = mul_p[FRAC_BITS +: bwcb_pkg::W_W];
  assign sum_ext  = {1'b0, sum_q[ctrl.chan]} + (SUM_W+1)'(add);
  assign sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_tint_q <= 1'b0;
    end else if (cfg_we_i) begin
      bone_tint_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_item) begin
      idx_q    <= bone_index_i[IDX_W-1:0];
      weight_q <= weight_i;
      last_q   <= last_entry_i;
    end
    if (ctrl.load_digits) begin
      x_q   <= ctrl.load_item ? bone_index_i[IDX_W-1:0] : idx_q;
      num_q <= '0;
      den_q <= DEN_W'(1);
    end else if (ctrl.digit_upd) begin
      x_q   <= quo;
      num_q <= num_next;
      den_q <= den_next;
    end
    if (ctrl.div_init) begin
      rem_q <= num_q;
    end else if (ctrl.div_step) begin
      rem_q <= rem_next;
      col_q <= {col_q[FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl.div_init) begin
      cnt_q <= '0;
    end else if (ctrl.div_step) begin
      cnt_q <= CNT_W'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (ctrl.emit) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (ctrl.mac_acc) begin
      sum_q[ctrl.chan] <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      red_q   <= bone_tint_q ? clamp_one(sum_q[0]) : bwcb_pkg::ONE_Q16;
      green_q <= bone_tint_q ? clamp_one(sum_q[1]) : bwcb_pkg::ONE_Q16;
      blue_q  <= bone_tint_q ? clamp_one(sum_q[2]) : bwcb_pkg::ONE_Q16;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef ASSERT_OFF
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && !bone_tint_q) |=>
      (red_o == bwcb_pkg::ONE_Q16 && green_o == bwcb_pkg::ONE_Q16 &&
       blue_o == bwcb_pkg::ONE_Q16))
    else $error("white result not produced");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0))
    else $error("channel sums not cleared after result");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.div_step |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o <= bwcb_pkg::ONE_Q16 && green_o <= bwcb_pkg::ONE_Q16 &&
                     blue_o <= bwcb_pkg::ONE_Q16))
    else $error("result above one");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int BONE_BITS = 8;
  localparam int FRAC_BITS = 16;
  localparam bit MODE_WHITE = 1'b0;
  localparam bit MODE_COLOR = 1'b1;
  localparam logic [bwcb_pkg::W_W-1:0] W_MAX = {bwcb_pkg::W_W{1'b1}};
  localparam longint unsigned SUM_LIMIT = (64'd1 << bwcb_pkg::SUM_W) - 1;
  localparam int RAND_ITEMS = 1950;
  localparam int RAND_PHASES = 6;
  localparam int SETTLE_CYCLES = 120;
  localparam int DRAIN_CYCLES = 150;
  localparam int LONG_HOLD = 2000;
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    logic [bwcb_pkg::OUT_W-1:0] red;
    logic [bwcb_pkg::OUT_W-1:0] green;
    logic [bwcb_pkg::OUT_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    bit                            mode;
    logic [bwcb_pkg::IDX_IN_W-1:0] idx;
    logic [bwcb_pkg::W_W-1:0]      weight;
    bit                            last;
    bit                            typed;
    rgb_t                          want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic                          cfg_wdata = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [bwcb_pkg::IDX_IN_W-1:0] bone_index = '0;
  logic [bwcb_pkg::W_W-1:0]      weight = '0;
  logic                          last_entry = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [bwcb_pkg::OUT_W-1:0]    red;
  logic [bwcb_pkg::OUT_W-1:0]    green;
  logic [bwcb_pkg::OUT_W-1:0]    blue;

  rgb_t                       pending_rgb[$];
  logic [bwcb_pkg::SUM_W-1:0] channel_sum[3] = '{default: '0};
  bit                         blend_mode = MODE_WHITE;
  int unsigned                halton_base[3] = '{2, 3, 5};
  int                         burst_left = 0;
  bit                         long_hold_req = 1'b0;
  int                         long_holds = 0;
  int                         err_count = 0;
  int                         entry_count = 0;
  int                         vertex_count = 0;
  int                         cfg_writes = 0;
  bit                         phase_mode[RAND_PHASES] =
      '{MODE_COLOR, MODE_WHITE, MODE_COLOR, MODE_COLOR, MODE_WHITE, MODE_COLOR};

  // Rows with a typed result check it directly; the rest rely on the predictor.
  dir_row_t dir_rows[DIR_ROWS] = '{
    '{MODE_WHITE, 8'd0,   17'd0,      1'b1, 1'b1,
      '{bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16}},
    '{MODE_WHITE, 8'd255, W_MAX,      1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_WHITE, 8'd170, bwcb_pkg::ONE_Q16, 1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_WHITE, 8'd85,  17'd1,      1'b1, 1'b1,
      '{bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16}},
    '{MODE_COLOR, 8'd0,   W_MAX,      1'b1, 1'b1, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd1,   bwcb_pkg::ONE_Q16, 1'b1, 1'b1,
      '{17'd32768, 17'd21845, 17'd13107}},
    '{MODE_COLOR, 8'd255, 17'd0,      1'b1, 1'b1, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd255, W_MAX,      1'b1, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd1,   W_MAX,      1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd1,   W_MAX,      1'b1, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd2,   bwcb_pkg::ONE_Q16, 1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd3,   17'd32768,  1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd4,   17'd16384,  1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd128, 17'd16384,  1'b1, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd85,  17'd65535,  1'b1, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd170, bwcb_pkg::ONE_Q16, 1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_WHITE, 8'd7,   17'd99999,  1'b1, 1'b1,
      '{bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16, bwcb_pkg::ONE_Q16}},
    '{MODE_COLOR, 8'd1,   bwcb_pkg::ONE_Q16, 1'b1, 1'b1,
      '{17'd32768, 17'd21845, 17'd13107}},
    '{MODE_COLOR, 8'd254, 17'd65537,  1'b0, 1'b0, '{17'd0, 17'd0, 17'd0}},
    '{MODE_COLOR, 8'd127, W_MAX,      1'b1, 1'b0, '{17'd0, 17'd0, 17'd0}}
  };

  bone_weight_color_blend #(
    .BONE_BITS(BONE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .bone_index_i (bone_index),
    .weight_i     (weight),
    .last_entry_i (last_entry),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned halton_q16(input logic [bwcb_pkg::IDX_IN_W-1:0] idx,
                                                input int unsigned base);
    longint unsigned n;
    longint unsigned num;
    longint unsigned den;
    n = idx & ((64'd1 << BONE_BITS) - 1);
    num = 0;
    den = 1;
    while (n > 0) begin
      num = num * base + n % base;
      den = den * base;
      n = n / base;
    end
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic bit blend_entry(input logic [bwcb_pkg::IDX_IN_W-1:0] idx,
                                     input logic [bwcb_pkg::W_W-1:0] w,
                                     input bit last, output rgb_t rgb);
    longint unsigned acc;
    logic [bwcb_pkg::OUT_W-1:0] ch[3];
    int c;
    rgb = '0;
    if (blend_mode == MODE_COLOR) begin
      for (c = 0; c < 3; c++) begin
        acc = channel_sum[c] + ((halton_q16(idx, halton_base[c]) * w) >> FRAC_BITS);
        channel_sum[c] = bwcb_pkg::SUM_W'((acc > SUM_LIMIT) ? SUM_LIMIT : acc);
      end
    end
    if (!last) return 1'b0;
    for (c = 0; c < 3; c++) begin
      if (blend_mode == MODE_WHITE || channel_sum[c] > bwcb_pkg::ONE_Q16) begin
        ch[c] = bwcb_pkg::ONE_Q16;
      end else begin
        ch[c] = bwcb_pkg::OUT_W'(channel_sum[c]);
      end
      channel_sum[c] = '0;
    end
    rgb.red = ch[0];
    rgb.green = ch[1];
    rgb.blue = ch[2];
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_entry(input logic [bwcb_pkg::IDX_IN_W-1:0] idx,
                             input logic [bwcb_pkg::W_W-1:0] w,
                             input bit last, input bit typed, input rgb_t typed_rgb);
    rgb_t rgb;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    bone_index <= idx;
    weight <= w;
    last_entry <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (blend_entry(idx, w, last, rgb)) begin
      pending_rgb.insert(pending_rgb.size(), typed ? typed_rgb : rgb);
    end
    entry_count++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic set_tint_mode(input bit mode);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    blend_mode = mode;
    cfg_writes++;
  endtask

  initial begin
    int k;
    repeat (LONG_HOLD / 2) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_holds++;
      end
      case ($urandom_range(0, 3))
        0: for (k = $urandom_range(1, 64); k > 0; k--) begin
          out_ready <= 1'b1;
          @(negedge clk);
        end
        1: for (k = $urandom_range(1, 64); k > 0; k--) begin
          out_ready <= 1'($urandom_range(0, 1));
          @(negedge clk);
        end
        2: for (k = $urandom_range(1, 64); k > 0; k--) begin
          out_ready <= ($urandom_range(0, 3) == 0);
          @(negedge clk);
        end
        default: for (k = $urandom_range(1, 64); k > 0; k--) begin
          out_ready <= k[0];
          @(negedge clk);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        $error("Unexpected vertex color red=%0d green=%0d blue=%0d", red, green, blue);
        err_count++;
      end else begin
        if (red !== pending_rgb[0].red) begin
          $error("red: expected %0d, actual %0d", pending_rgb[0].red, red);
          err_count++;
        end
        if (green !== pending_rgb[0].green) begin
          $error("green: expected %0d, actual %0d", pending_rgb[0].green, green);
          err_count++;
        end
        if (blue !== pending_rgb[0].blue) begin
          $error("blue: expected %0d, actual %0d", pending_rgb[0].blue, blue);
          err_count++;
        end
        void'(pending_rgb.pop_front());
        vertex_count++;
      end
    end
  end

  initial begin
    #10ms;
    $display("bone_weight_color_blend test failed");
    $finish;
  end

  initial begin
    int p;
    int e;
    int n;
    int phase_items;
    bit noisy;
    bit last;
    logic [bwcb_pkg::IDX_IN_W-1:0] idx;
    logic [bwcb_pkg::W_W-1:0] w;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != blend_mode) set_tint_mode(dir_rows[i].mode);
      offer_entry(dir_rows[i].idx, dir_rows[i].weight, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    // Mostly well-formed vertices of one to four entries; some carry random last flags.
    for (p = 0; p < RAND_PHASES; p++) begin
      set_tint_mode(phase_mode[p]);
      if (p == 2) long_hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < RAND_ITEMS / RAND_PHASES) begin
        n = $urandom_range(1, 4);
        noisy = ($urandom_range(0, 9) == 0);
        for (e = 0; e < n; e++) begin
          idx = ($urandom_range(0, 4) == 0) ? bwcb_pkg::IDX_IN_W'($urandom_range(0, 7))
                                            : bwcb_pkg::IDX_IN_W'($urandom_range(0, 255));
          case ($urandom_range(0, 9))
            0: w = '0;
            1: w = bwcb_pkg::ONE_Q16;
            2: w = W_MAX;
            3, 4: w = bwcb_pkg::W_W'($urandom_range(0, W_MAX));
            default: w = bwcb_pkg::W_W'($urandom_range(0, bwcb_pkg::ONE_Q16 / n));
          endcase
          last = noisy ? bit'($urandom_range(0, 1)) : (e == n - 1);
          offer_entry(idx, w, last, 1'b0, '0);
          phase_items++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d skinning entries and %0d checked vertex colors over %0d writes",
             entry_count, vertex_count, cfg_writes);
    $display("of the blend mode in both modes, with %0d long output stalls.", long_holds);
    if (err_count == 0) begin
      $display("bone_weight_color_blend test passed");
    end else begin
      $display("bone_weight_color_blend test failed");
    end
    $finish;
  end

endmodule
